// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication, disabled in reset
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// clocked next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ----- sv/smdu_pkg.sv -----
package smdu_pkg;
   localparam int unsigned Width = 16;
   localparam int unsigned Stages = Width + 1;

   typedef enum logic [3:0] {
      MODE_MULU8X8   = 4'd0,
      MODE_MULS8X8   = 4'd1,
      MODE_MULU16X8  = 4'd2,
      MODE_MULU16X16 = 4'd3,
      MODE_DIVU16_8  = 4'd4,
      MODE_DIVU16_16 = 4'd5,
      MODE_DIVS16_8  = 4'd6,
      MODE_DIVS16_16 = 4'd7,
      MODE_MODU8_8   = 4'd8
   } mode_type;

   // one in-flight operation as it moves along the cell row
   typedef struct packed {
      logic              valid;
      logic              is_div;
      logic              is_zero;   // output forced to zero (unused mode)
      logic              dz;        // divisor zero
      logic              neg;       // negate quotient at the end
      logic [1:0]        rem_kind;  // 0: 16-bit rem, 1: 8-bit rem, 2: mod
      logic [Width-1:0]  acc;       // product accumulator / partial remainder
      logic [Width-1:0]  a;         // multiplicand / dividend (shifted out msb first)
      logic [Width-1:0]  b;         // multiplier / divisor
      logic [Width-1:0]  q;         // quotient bits
      logic [Width-1:0]  dz_rem;    // remainder to report on zero divisor
   } slot_type;

   localparam logic [1:0] REM_16  = 2'd0;
   localparam logic [1:0] REM_8   = 2'd1;
   localparam logic [1:0] REM_MOD = 2'd2;
endpackage

// ----- sv/smdu_cell.sv -----
// One bit step: add-shift for multiply, restoring compare-subtract for divide.
module smdu_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [3:0]         bit_index,
   input  smdu_pkg::slot_type slot_in,
   output smdu_pkg::slot_type slot_out
);
   import smdu_pkg::*;

   slot_type slot_ff, slot_in_w;
   logic [Width:0] trial;
   logic [Width-1:0] partial;

   // divide steps walk the dividend msb first: bit (15 - bit_index)
   always_comb begin
      slot_in_w = slot_in;
      partial = '0;
      trial = '0;
      if (slot_in.is_div) begin
         partial = {slot_in.acc[Width-2:0], slot_in.a[~bit_index]};
         trial = {slot_in.acc[Width-1], partial} - {1'b0, slot_in.b};
         if (!trial[Width]) begin
            slot_in_w.acc = trial[Width-1:0];
            slot_in_w.q[~bit_index] = 1'b1;
         end else begin
            slot_in_w.acc = partial;
         end
      end else if (slot_in.b[bit_index]) begin
         slot_in_w.acc = slot_in.acc + (slot_in.a << bit_index);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else if (advance) begin
         slot_ff <= slot_in_w;
      end
   end

   assign slot_out = slot_ff;
endmodule

// ----- sv/small_int_mul_div_unit.sv -----
// Integer multiply / divide unit.
// req_ channel: mode, operand_a, operand_b; rsp_ channel: product_or_quotient,
// remainder, divide_by_zero. Both use valid/ready; a transaction moves when
// valid and ready are high at a rising edge.
// Operations are decoded in an input stage, then pass a row of 16 bit cells
// (one shift-add or restoring subtract step each), then a finishing stage that
// applies the quotient sign and selects the outputs into the output register.
// A new transaction can be accepted every cycle unless a waiting result stalls
// the output; the whole row advances as one pipeline.
// When the receiver stalls with a result waiting, the whole row holds and
// req_ready stays low until rsp_ready returns; bubbles in the row are not
// collapsed, so the row stalls as a unit.
// Reset (synchronous, active high) empties the row and the output register.
// Unused modes return all zero fields with no flag.
module small_int_mul_div_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_mode,
   input  logic [15:0] req_operand_a,
   input  logic [15:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_product_or_quotient,
   output logic [15:0] rsp_remainder,
   output logic        rsp_divide_by_zero
);
   import smdu_pkg::*;
   `include "assert_macros.svh"

   slot_type row [Stages];
   slot_type entry_ff, entry_in;
   logic advance;
   logic [15:0] qn, q_final, r_final;
   logic [15:0] rsp_q_ff, rsp_q_in, rsp_r_ff, rsp_r_in;
   logic rsp_valid_ff, rsp_dz_ff, rsp_dz_in;
   slot_type tail;
   logic [15:0] ma, mb;
   logic [7:0] a8, b8;

   // whole pipeline moves when the output register can take the tail
   assign advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      a8 = req_operand_a[7:0];
      b8 = req_operand_b[7:0];
      ma = req_operand_a[15] ? 16'(-req_operand_a) : req_operand_a;
      mb = '0;
      entry_in = '0;
      entry_in.valid = req_valid;
      case (req_mode)
         MODE_MULU8X8: begin
            entry_in.a = {8'h00, a8};
            entry_in.b = {8'h00, b8};
         end
         MODE_MULS8X8: begin
            entry_in.a = {{8{a8[7]}}, a8};
            entry_in.b = {{8{b8[7]}}, b8};
         end
         MODE_MULU16X8: begin
            entry_in.a = req_operand_a;
            entry_in.b = {8'h00, b8};
         end
         MODE_MULU16X16: begin
            entry_in.a = req_operand_a;
            entry_in.b = req_operand_b;
         end
         MODE_DIVU16_8, MODE_DIVS16_8: begin
            entry_in.is_div = 1'b1;
            entry_in.rem_kind = REM_8;
            if (req_mode == MODE_DIVS16_8) begin
               mb = {8'h00, b8[7] ? 8'(-b8) : b8};
               entry_in.a = ma;
               entry_in.neg = req_operand_a[15] ^ b8[7];
            end else begin
               mb = {8'h00, b8};
               entry_in.a = req_operand_a;
            end
            entry_in.b = mb;
            entry_in.dz = (b8 == 8'h00);
            entry_in.dz_rem = {8'h00, entry_in.a[7:0]};
         end
         MODE_DIVU16_16, MODE_DIVS16_16: begin
            entry_in.is_div = 1'b1;
            entry_in.rem_kind = REM_16;
            if (req_mode == MODE_DIVS16_16) begin
               mb = req_operand_b[15] ? 16'(-req_operand_b) : req_operand_b;
               entry_in.a = ma;
               entry_in.neg = req_operand_a[15] ^ req_operand_b[15];
            end else begin
               mb = req_operand_b;
               entry_in.a = req_operand_a;
            end
            entry_in.b = mb;
            entry_in.dz = (req_operand_b == 16'h0000);
            entry_in.dz_rem = entry_in.a;
         end
         MODE_MODU8_8: begin
            entry_in.is_div = 1'b1;
            entry_in.rem_kind = REM_MOD;
            entry_in.a = {8'h00, a8};
            entry_in.b = {8'h00, b8};
            entry_in.dz = (b8 == 8'h00);
            entry_in.dz_rem = {8'h00, a8};
         end
         default: entry_in.is_zero = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign row[0] = entry_ff;

   for (genvar i = 0; i < Width; i++) begin : g_cell
      smdu_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .bit_index (4'(i)),
         .slot_in   (row[i]),
         .slot_out  (row[i+1])
      );
   end

   assign tail = row[Width];

   always_comb begin
      qn = tail.neg ? 16'(-tail.q) : tail.q;
      q_final = '0;
      r_final = '0;
      if (tail.is_zero) begin
         q_final = '0;
      end else if (!tail.is_div) begin
         q_final = tail.acc;
      end else if (tail.dz) begin
         q_final = (tail.rem_kind == REM_MOD) ? tail.dz_rem : 16'hFFFF;
         r_final = tail.dz_rem;
      end else begin
         r_final = tail.acc;
         q_final = (tail.rem_kind == REM_MOD) ? tail.acc : qn;
      end
      rsp_q_in = q_final;
      rsp_r_in = r_final;
      rsp_dz_in = tail.is_div && tail.dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tail.valid;
         rsp_q_ff <= rsp_q_in;
         rsp_r_ff <= rsp_r_in;
         rsp_dz_ff <= rsp_dz_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_product_or_quotient = rsp_q_ff;
   assign rsp_remainder = rsp_r_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

   `ASSERT_NEXT(a_hold_on_stall, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_product_or_quotient))
   `ASSERT_IMPL(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   `ASSERT_IMPL(a_dz_only_div, clock, reset, rsp_valid && rsp_divide_by_zero,
      rsp_product_or_quotient == 16'hFFFF || rsp_product_or_quotient[15:8] == 8'h00)
endmodule
